[rtl/deq_pkg.sv]
// Shared types and constants for the double-ended queue unit.
`default_nettype none

package deq_pkg;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_PUSH_BACK  = 3'd0,
        MODE_PUSH_FRONT = 3'd1,
        MODE_POP_BACK   = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_PEEK       = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    // Per-cycle command broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CELL_HOLD       = 3'd0,
        CELL_SHIFT_IN   = 3'd1,
        CELL_SHIFT_OUT  = 3'd2,
        CELL_APPEND     = 3'd3,
        CELL_DROP       = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [WORD_W-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [WORD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic [CNT_W-1:0]         count;
        logic                     empty_res;
        logic [1:0]               error;
    } result_t;

endpackage

`default_nettype wire

[rtl/deq_cell.sv]
// One storage cell of the queue row: a word and its occupied bit.
`default_nettype none

module deq_cell (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire deq_pkg::cell_ctrl_t                 ctrl,
    input  wire logic signed [deq_pkg::WORD_W-1:0]   left_data,
    input  wire logic                                left_valid,
    input  wire logic signed [deq_pkg::WORD_W-1:0]   right_data,
    input  wire logic                                right_valid,
    output logic signed [deq_pkg::WORD_W-1:0]        data,
    output logic                                     valid,
    output logic                                     is_back
);

    logic signed [deq_pkg::WORD_W-1:0] data_reg;
    logic signed [deq_pkg::WORD_W-1:0] data_next;
    logic                              valid_reg;
    logic                              valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            deq_pkg::CELL_SHIFT_IN:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            deq_pkg::CELL_SHIFT_OUT:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            deq_pkg::CELL_APPEND:
            begin
                // first free cell takes the word
                if (!valid_reg && left_valid)
                begin
                    data_next  = ctrl.value;
                    valid_next = 1'b1;
                end
            end
            deq_pkg::CELL_DROP:
            begin
                if (valid_reg && !right_valid)
                    valid_next = 1'b0;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign valid   = valid_reg;
    assign is_back = valid_reg && !right_valid;

endmodule

`default_nettype wire

[rtl/double_ended_queue_unit.sv]
// Top level of the double-ended queue unit: command decode and the cell row.
//
// Usage
//   Command channel: drive cmd (mode, value) and raise start; the command is
//   transferred at a rising edge where start is high and busy is low. busy
//   stays low, so one command may be transferred every cycle.
//   Result channel: exactly one result per command. It appears on result in
//   the cycle right after the transfer, marked by done for that one cycle.
//   The receiver cannot stall; a result not taken in its cycle is gone.
//   Throughput is one command per cycle: every cell of the row updates
//   in the transfer cycle, and the result reads the front cell and the
//   cell marked as back from the updated row.
//   Storage is a row of DEPTH cells. The front word always sits in cell 0;
//   a push at the front shifts the row toward the back, a pop at the front
//   shifts it toward the front, a push at the back fills the first free
//   cell, a pop at the back frees the last occupied cell.
//   Reset clears the occupied bits and the count; stored words need none.
//   Pushes on a full row and pops on an empty row leave the row unchanged
//   and report an error code. Unused mode codes act as peek.
`default_nettype none

module double_ended_queue_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire deq_pkg::cmd_t    cmd,
    output logic                  done,
    output deq_pkg::result_t      result
);

    localparam int DEPTH = deq_pkg::DEPTH;

    logic                                accept;
    deq_pkg::cell_ctrl_t                 ctrl;
    logic [deq_pkg::CNT_W-1:0]           count_reg;
    logic [deq_pkg::CNT_W-1:0]           count_next;
    deq_pkg::err_t                       err_reg;
    deq_pkg::err_t                       err_next;
    logic                                done_reg;
    logic                                full;
    logic                                empty;

    logic signed [deq_pkg::WORD_W-1:0]   cell_data  [DEPTH];
    logic [DEPTH-1:0]                    cell_valid;
    logic [DEPTH-1:0]                    cell_back;
    logic signed [deq_pkg::WORD_W-1:0]   back_word;

    // Every command is taken on arrival.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == deq_pkg::CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);

    // Decode the command into one row operation; drop pushes on full and
    // pops on empty so the row holds.
    always_comb
    begin
        ctrl.op    = deq_pkg::CELL_HOLD;
        ctrl.value = cmd.value;
        count_next = count_reg;
        err_next   = deq_pkg::ERR_OK;
        if (accept)
        begin
            unique case (cmd.mode)
                deq_pkg::MODE_PUSH_BACK,
                deq_pkg::MODE_PUSH_FRONT:
                begin
                    if (full)
                        err_next = deq_pkg::ERR_FULL;
                    else
                    begin
                        ctrl.op    = (cmd.mode == deq_pkg::MODE_PUSH_BACK) ?
                                     deq_pkg::CELL_APPEND : deq_pkg::CELL_SHIFT_IN;
                        count_next = count_reg + 1'b1;
                    end
                end
                deq_pkg::MODE_POP_BACK,
                deq_pkg::MODE_POP_FRONT:
                begin
                    if (empty)
                        err_next = deq_pkg::ERR_EMPTY;
                    else
                    begin
                        ctrl.op    = (cmd.mode == deq_pkg::MODE_POP_BACK) ?
                                     deq_pkg::CELL_DROP : deq_pkg::CELL_SHIFT_OUT;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    ctrl.op = deq_pkg::CELL_HOLD;
                end
            endcase
        end
    end

    // Cell row: cell 0 sees the incoming word as its left neighbor, the last
    // cell sees an empty right neighbor.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [deq_pkg::WORD_W-1:0] l_data;
        logic                              l_valid;
        logic signed [deq_pkg::WORD_W-1:0] r_data;
        logic                              r_valid;

        if (i == 0)
        begin : g_first
            assign l_data  = cmd.value;
            assign l_valid = 1'b1;
        end
        else
        begin : g_mid_l
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_data  = '0;
            assign r_valid = 1'b0;
        end
        else
        begin : g_mid_r
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
        end

        deq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i]),
            .is_back     (cell_back[i])
        );
    end

    // Pick the back word: at most one cell flags itself as back.
    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_back[i])
                back_word = back_word | cell_data[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            err_reg   <= deq_pkg::ERR_OK;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            err_reg   <= err_next;
            done_reg  <= accept;
        end
    end

    // Result reads the row as it stands after the transferred command.
    assign done               = done_reg;
    assign result.front_value = empty ? -32'sd1 : cell_data[0];
    assign result.back_value  = empty ? -32'sd1 : back_word;
    assign result.count       = count_reg;
    assign result.empty_res   = empty;
    assign result.error       = err_reg;

    a_count_matches_row: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(count_reg))
        else $error("occupied cells disagree with count");

    a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((({1'b0, cell_valid}) + 1'b1) & {1'b0, cell_valid}) == '0)
        else $error("occupied cells not packed from the front");

    a_one_back: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_back) && (empty || $onehot(cell_back)))
        else $error("back marker not unique");

    a_full_push_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && (cmd.mode == deq_pkg::MODE_PUSH_BACK ||
                            cmd.mode == deq_pkg::MODE_PUSH_FRONT))
        |=> (done && result.error == deq_pkg::ERR_FULL && $stable(cell_valid)))
        else $error("push on full row not flagged or not dropped");

    a_empty_pop_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && empty && (cmd.mode == deq_pkg::MODE_POP_BACK ||
                             cmd.mode == deq_pkg::MODE_POP_FRONT))
        |=> (done && result.error == deq_pkg::ERR_EMPTY && result.empty_res))
        else $error("pop on empty row not flagged");

endmodule

`default_nettype wire

[sim/tb_double_ended_queue_unit.sv]
// Testbench for the double-ended queue unit: directed and random commands against a ring predictor.
module tb_double_ended_queue_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    localparam int IDX_W        = $clog2(DEPTH);
    localparam int MODE_CODES   = 8;      // every value of the 3-bit mode field
    localparam int RANDOM_ITEMS = 1400;
    localparam int MAX_GAP      = 16;
    localparam int TAIL_CYCLES  = 4;      // latency of the last result plus margin
    localparam int STALL_LIMIT  = 500;    // far beyond the longest gap plus latency

    localparam logic signed [WORD_W-1:0] WORD_MAX   = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN   = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd   = '0;
    logic    busy;
    logic    done;
    result_t result;

    double_ended_queue_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: a ring of DEPTH words with a head index and a fill count.
    // Head and ring index wrap naturally at IDX_W bits (DEPTH is 2**IDX_W).
    // ------------------------------------------------------------------
    logic signed [WORD_W-1:0] ring_words [DEPTH];
    logic [IDX_W-1:0]         head_idx = '0;
    logic [CNT_W-1:0]         held     = '0;

    result_t view_queue[$];     // predicted results, oldest first
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    bit      pace_idle      = 1'b1;

    // Apply one command to the predicted ring and return the view after it.
    function automatic result_t apply_to_ring(cmd_t c);
        result_t v;
        v       = '0;
        v.error = ERR_OK;
        if (c.mode == MODE_PUSH_BACK || c.mode == MODE_PUSH_FRONT)
        begin
            if (held >= DEPTH)
                v.error = ERR_FULL;     // drop the word, keep the row
            else
            begin
                if (c.mode == MODE_PUSH_BACK)
                    ring_words[IDX_W'(head_idx + held)] = c.value;
                else
                begin
                    head_idx             = head_idx - 1'b1;
                    ring_words[head_idx] = c.value;
                end
                held = held + 1'b1;
            end
        end
        else if (c.mode == MODE_POP_BACK || c.mode == MODE_POP_FRONT)
        begin
            if (held == 0)
                v.error = ERR_EMPTY;
            else
            begin
                if (c.mode == MODE_POP_FRONT)
                    head_idx = head_idx + 1'b1;
                held = held - 1'b1;
            end
        end
        // peek and the unused codes leave the ring as it is

        v.count     = held;
        v.empty_res = (held == 0);
        if (held != 0)
        begin
            v.front_value = ring_words[head_idx];
            v.back_value  = ring_words[IDX_W'(head_idx + held - 1'b1)];
        end
        else
        begin
            v.front_value = EMPTY_WORD;
            v.back_value  = EMPTY_WORD;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Monitor: check the result strobed in the cycle just ended, then
    // record the prediction for a command transferred at this edge.
    // Sampling at the edge reads pre-edge values of every port.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (view_queue.size() == 0)
                    report_mismatch("result strobe with no command pending");
                else
                begin
                    want = view_queue[0];
                    view_queue.delete(0);
                    if (result.front_value !== want.front_value)
                        report_mismatch($sformatf("front_value got %0d want %0d",
                                                  result.front_value, want.front_value));
                    if (result.back_value !== want.back_value)
                        report_mismatch($sformatf("back_value got %0d want %0d",
                                                  result.back_value, want.back_value));
                    if (result.count !== want.count)
                        report_mismatch($sformatf("count got %0d want %0d",
                                                  result.count, want.count));
                    if (result.empty_res !== want.empty_res)
                        report_mismatch($sformatf("empty_res got %b want %b",
                                                  result.empty_res, want.empty_res));
                    if (result.error !== want.error)
                        report_mismatch($sformatf("error got %0d want %0d",
                                                  result.error, want.error));
                end
            end

            if (start && !busy)
                view_queue.insert(view_queue.size(), apply_to_ring(cmd));

            // Watchdog: count edges with neither a command nor a result transfer.
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Draw a word, leaning on the extremes and the empty marker.
    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return EMPTY_WORD;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    // Transfer one command; idle a random number of cycles first when pacing is on.
    task automatic send_cmd(input logic [2:0] op_code, input logic signed [WORD_W-1:0] word);
        int gap;
        gap = pace_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            cmd   <= '{mode: 3'($urandom()), value: $urandom()};   // junk on an idle bus
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= '{mode: op_code, value: word};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Hold off new commands until every predicted result has come back.
    task automatic wait_for_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (view_queue.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reads and pops on the row straight out of reset.
    task automatic test_empty_row();
        send_cmd(MODE_PEEK, pick_word());
        send_cmd(MODE_POP_BACK, pick_word());
        send_cmd(MODE_POP_FRONT, pick_word());
    endtask

    // Push front then back into an empty row, pop both ends; a lone word is both front and back.
    task automatic test_single_word();
        send_cmd(MODE_PUSH_FRONT, WORD_MAX);
        send_cmd(MODE_PUSH_BACK, WORD_MIN);
        send_cmd(MODE_POP_FRONT, pick_word());
        send_cmd(MODE_POP_BACK, pick_word());
    endtask

    // Fill the row from both ends, then push on a full row at each end.
    task automatic test_full_row();
        for (int i = 0; i < DEPTH; i++)
            send_cmd((i % 2 == 0) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_word());
        send_cmd(MODE_PUSH_BACK, pick_word());
        send_cmd(MODE_PUSH_FRONT, pick_word());
    endtask

    // Codes above peek must act as peek.
    task automatic test_unused_codes();
        for (int m = int'(MODE_PEEK) + 1; m < MODE_CODES; m++)
            send_cmd(3'(m), pick_word());
    endtask

    // Episodes that lean toward filling, draining or churning, so the row
    // keeps hitting full and empty and the head wraps in both directions.
    task automatic test_random_traffic();
        int         issued;
        int         lean;
        int         span;
        int         roll;
        int         push_share;
        logic [2:0] op_code;
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            lean       = $urandom_range(0, 2);
            span       = $urandom_range(8, 48);
            pace_idle  = ($urandom_range(0, 3) != 0);     // some back-to-back stretches
            push_share = (lean == 0) ? 65 : (lean == 1) ? 25 : 45;
            for (int i = 0; i < span; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < push_share)
                    op_code = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
                else if (roll < 90)
                    op_code = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
                else
                    op_code = 3'($urandom_range(int'(MODE_PEEK), MODE_CODES - 1));
                send_cmd(op_code, pick_word());
                issued++;
            end
        end
        pace_idle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_row();
        test_single_word();
        test_full_row();
        test_unused_codes();
        wait_for_results();
        test_random_traffic();

        // Drain: stop commands, let the last result land, then allow for latency.
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (view_queue.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived", view_queue.size()));

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
